FILE: rtl/usart_async_tx_rx_macros.svh
// Assertion macros shared by the serial port RTL.
`ifndef USART_ASYNC_TX_RX_MACROS_SVH
`define USART_ASYNC_TX_RX_MACROS_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define USART_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("usart assertion failed");
// Checked on every clock edge, reset included.
`define USART_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("usart assertion failed");
`else
`define USART_ASSERT(lbl, prop)
`define USART_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/usart_pkg.sv
// Types and constants of the asynchronous serial port.
package usart_pkg;

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  // Command queue between decoder and engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_EN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_NINE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_NINTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_CONT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_NINE    = 3'd5;

  // Frame lengths
  localparam logic [3:0] TX_BITS_NINE  = 4'd12;
  localparam logic [3:0] TX_BITS_EIGHT = 4'd11;
  localparam logic [3:0] RX_BITS_NINE  = 4'd9;
  localparam logic [3:0] RX_BITS_EIGHT = 4'd8;

  typedef enum logic [2:0] {
    ACT_TX_TICK   = 3'd0,
    ACT_RX_EDGE   = 3'd1,
    ACT_RX_SAMPLE = 3'd2,
    ACT_TX_WRITE  = 3'd3,
    ACT_RX_READ   = 3'd4,
    ACT_NOP       = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    RX_OFF   = 2'd0,
    RX_WAIT  = 2'd1,
    RX_START = 2'd2,
    RX_DATA  = 2'd3
  } rx_phase_t;

  // Decoded command, as queued for the engine
  typedef struct packed {
    act_t       act;
    logic       level;
    logic       sample;
    logic [7:0] data;
  } cmd_t;

  // Result beat layout, lowest bit last
  typedef struct packed {
    logic [2:0] pad;
    logic       rx_overrun;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       tx_shifter_empty;
    logic       tx_buffer_empty;
    logic       tx_line;
  } res_t;

endpackage

FILE: rtl/usart_cmd_queue.sv
// Input decoder and two-entry command queue in front of the engine.
module usart_cmd_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] rx_level, [3:1] rx_samples, [11:4] tx_byte, [15:12] zero
  input  logic [usart_pkg::IN_DATA_W-1:0]     s_tdata,
  // [2:0] action
  input  logic [usart_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                                q_valid,
  output usart_pkg::cmd_t                     q_cmd,
  input  logic                                q_pop
);

  usart_pkg::cmd_t                    entry [usart_pkg::QUEUE_DEPTH];
  usart_pkg::cmd_t                    cmd_in;
  logic [usart_pkg::QPTR_W-1:0]       wr_ptr;
  logic [usart_pkg::QPTR_W-1:0]       rd_ptr;
  logic [usart_pkg::QCNT_W-1:0]       count;
  logic                               push;
  logic                               pop;
  logic [2:0]                         smp;

  // Classify the beat: unused action codes become no-ops, samples voted
  assign smp = s_tdata[3:1];
  always_comb begin
    cmd_in.act    = (s_tuser <= 3'(usart_pkg::ACT_RX_READ)) ?
                    usart_pkg::act_t'(s_tuser) : usart_pkg::ACT_NOP;
    cmd_in.level  = s_tdata[0];
    cmd_in.sample = (smp[0] & smp[1]) | (smp[0] & smp[2]) | (smp[1] & smp[2]);
    cmd_in.data   = s_tdata[11:4];
  end

  assign s_tready = (count != usart_pkg::QCNT_W'(usart_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid & s_tready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop & q_valid;
  assign q_cmd    = entry[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + usart_pkg::QCNT_W'(push) - usart_pkg::QCNT_W'(pop);
    end
  end

`include "usart_async_tx_rx_macros.svh"

  `USART_ASSERT(a_queue_bound, count <= usart_pkg::QCNT_W'(usart_pkg::QUEUE_DEPTH))

endmodule

FILE: rtl/usart_engine.sv
// Serial port state, command execution and result register.
module usart_engine #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [usart_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                                cfg_data,
  input  logic                                q_valid,
  input  usart_pkg::cmd_t                     q_cmd,
  output logic                                q_pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [usart_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration
  logic port_en, tx_en, tx_nine, tx_ninth, rx_cont, rx_nine;
  logic port_en_next, tx_en_next, tx_nine_next, tx_ninth_next;
  logic rx_cont_next, rx_nine_next;

  // Transmitter
  logic [7:0]  hold_byte, hold_byte_next;
  logic        hold_full, hold_full_next;
  logic [11:0] tx_frame, tx_frame_next;
  logic [3:0]  tx_bits_left, tx_bits_left_next;
  logic        tx_level, tx_level_next;

  // Receiver
  usart_pkg::rx_phase_t rx_phase, rx_phase_next;
  logic [9:0]  rx_frame, rx_frame_next;
  logic [3:0]  rx_bits_left, rx_bits_left_next;
  logic        line_level, line_level_next;

  // Receive FIFO
  logic [7:0]       fifo_store [FIFO_DEPTH];
  logic [CNT_W-1:0] fifo_count, fifo_count_next;
  logic             overrun, overrun_next;
  logic             fifo_push, fifo_pop;
  logic [7:0]       push_byte;

  logic             fire;
  logic             cfg_we;
  usart_pkg::res_t  res;

  function automatic logic [11:0] load_frame(input logic [7:0] b, input logic nine,
                                             input logic ninth);
    load_frame = {(nine ? {2'b11, ninth} : 3'b011), b, 1'b0};
  endfunction

  // A register write holds off the command for that cycle
  assign cfg_we = cfg_valid;
  assign fire   = q_valid & (~m_tvalid | m_tready) & ~cfg_we;
  assign q_pop  = fire;

  // Next state: configuration write or one command
  always_comb begin
    logic old_port;
    logic old_cont;
    logic do_rc;
    logic skip;

    port_en_next      = port_en;
    tx_en_next        = tx_en;
    tx_nine_next      = tx_nine;
    tx_ninth_next     = tx_ninth;
    rx_cont_next      = rx_cont;
    rx_nine_next      = rx_nine;
    hold_byte_next    = hold_byte;
    hold_full_next    = hold_full;
    tx_frame_next     = tx_frame;
    tx_bits_left_next = tx_bits_left;
    tx_level_next     = tx_level;
    rx_phase_next     = rx_phase;
    rx_frame_next     = rx_frame;
    rx_bits_left_next = rx_bits_left;
    line_level_next   = line_level;
    fifo_count_next   = fifo_count;
    overrun_next      = overrun;
    fifo_push         = 1'b0;
    fifo_pop          = 1'b0;
    push_byte         = rx_frame[7:0];
    old_port          = port_en;
    old_cont          = rx_cont;
    do_rc             = 1'b0;
    skip              = 1'b0;

    if (cfg_we) begin
      priority case (cfg_index)
        usart_pkg::CFG_PORT_EN: begin
          port_en_next = cfg_data;
          do_rc        = 1'b1;
        end
        usart_pkg::CFG_TX_EN: begin
          if (cfg_data != tx_en) begin
            tx_en_next = cfg_data;
            if (cfg_data) begin
              hold_full_next = 1'b0;
            end else begin
              tx_bits_left_next = '0;
            end
          end
        end
        usart_pkg::CFG_TX_NINE:  tx_nine_next  = cfg_data;
        usart_pkg::CFG_TX_NINTH: tx_ninth_next = cfg_data;
        usart_pkg::CFG_RX_CONT: begin
          rx_cont_next = cfg_data;
          do_rc        = 1'b1;
        end
        usart_pkg::CFG_RX_NINE: begin
          rx_nine_next = cfg_data;
          do_rc        = 1'b1;
        end
        default: ;
      endcase

      // Port and receiver enable handling
      if (do_rc) begin
        if (old_port != port_en_next) begin
          if (port_en_next) begin
            tx_level_next  = 1'b1;
            hold_full_next = 1'b0;
          end else begin
            tx_bits_left_next = '0;
            hold_full_next    = 1'b1;
            rx_frame_next     = '0;
            rx_bits_left_next = '0;
            rx_phase_next     = usart_pkg::RX_OFF;
            skip              = 1'b1;
          end
        end
        if (!skip) begin
          if (port_en_next && rx_cont_next) begin
            if (old_port != port_en_next || old_cont != rx_cont_next) begin
              rx_frame_next     = '0;
              rx_bits_left_next = rx_nine_next ? usart_pkg::RX_BITS_NINE
                                               : usart_pkg::RX_BITS_EIGHT;
              rx_phase_next     = line_level ? usart_pkg::RX_WAIT : usart_pkg::RX_START;
            end
          end else begin
            rx_phase_next = usart_pkg::RX_OFF;
          end
        end
      end
    end else if (fire) begin
      unique case (q_cmd.act)
        usart_pkg::ACT_TX_TICK: begin
          if (tx_bits_left != '0) begin
            tx_level_next     = tx_frame[0];
            tx_frame_next     = {1'b0, tx_frame[11:1]};
            tx_bits_left_next = tx_bits_left - 4'd1;
            if (tx_bits_left_next == '0 && hold_full) begin
              tx_frame_next     = load_frame(hold_byte, tx_nine, tx_ninth);
              tx_bits_left_next = tx_nine ? usart_pkg::TX_BITS_NINE
                                          : usart_pkg::TX_BITS_EIGHT;
              hold_full_next    = 1'b0;
            end
          end
        end
        usart_pkg::ACT_RX_EDGE: begin
          line_level_next = q_cmd.level;
          if (rx_phase == usart_pkg::RX_WAIT && !q_cmd.level && rx_cont) begin
            rx_phase_next = usart_pkg::RX_START;
          end
        end
        usart_pkg::ACT_RX_SAMPLE: begin
          if (rx_phase == usart_pkg::RX_START) begin
            rx_phase_next = q_cmd.sample ? usart_pkg::RX_WAIT : usart_pkg::RX_DATA;
          end else if (rx_phase == usart_pkg::RX_DATA) begin
            if (rx_bits_left == '0) begin
              // Stop bit: deliver a good frame, then re-arm or stop
              if (q_cmd.sample) begin
                push_byte = rx_nine ? rx_frame[7:0] : rx_frame[8:1];
                if (fifo_count >= CNT_W'(FIFO_DEPTH)) begin
                  overrun_next = 1'b1;
                end else begin
                  fifo_push       = 1'b1;
                  fifo_count_next = fifo_count + 1'b1;
                end
              end
              if (rx_cont) begin
                rx_frame_next     = '0;
                rx_bits_left_next = rx_nine ? usart_pkg::RX_BITS_NINE
                                            : usart_pkg::RX_BITS_EIGHT;
                rx_phase_next     = usart_pkg::RX_WAIT;
              end else begin
                rx_phase_next = usart_pkg::RX_OFF;
              end
            end else begin
              rx_frame_next     = {1'b0, q_cmd.sample | rx_frame[9], rx_frame[8:1]};
              rx_bits_left_next = rx_bits_left - 4'd1;
            end
          end
        end
        usart_pkg::ACT_TX_WRITE: begin
          hold_byte_next = q_cmd.data;
          hold_full_next = 1'b1;
          if (tx_bits_left == '0 && tx_en) begin
            tx_frame_next     = load_frame(q_cmd.data, tx_nine, tx_ninth);
            tx_bits_left_next = tx_nine ? usart_pkg::TX_BITS_NINE
                                        : usart_pkg::TX_BITS_EIGHT;
            hold_full_next    = 1'b0;
          end
        end
        usart_pkg::ACT_RX_READ: begin
          if (fifo_count != '0) begin
            fifo_pop        = 1'b1;
            fifo_count_next = fifo_count - 1'b1;
          end
        end
        usart_pkg::ACT_NOP: ;
        default: ;
      endcase
    end
  end

  // Result of the command
  always_comb begin
    res.pad              = '0;
    res.rx_overrun       = overrun_next;
    res.rx_ready         = (fifo_count_next != '0);
    res.rx_byte          = fifo_pop ? fifo_store[0] : 8'h00;
    res.tx_shifter_empty = (tx_bits_left_next == '0);
    res.tx_buffer_empty  = ~hold_full_next;
    res.tx_line          = tx_level_next;
  end

  // Receive FIFO entries: pop shifts towards the head, push fills at the tail
  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_fifo
    if (i < FIFO_DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (fifo_push && fifo_count == CNT_W'(i)) begin
          fifo_store[i] <= push_byte;
        end else if (fifo_pop) begin
          fifo_store[i] <= fifo_store[i+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (fifo_push && fifo_count == CNT_W'(i)) begin
          fifo_store[i] <= push_byte;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hold_byte <= hold_byte_next;
    if (fire) begin
      m_tdata <= res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      port_en      <= 1'b0;
      tx_en        <= 1'b0;
      tx_nine      <= 1'b0;
      tx_ninth     <= 1'b0;
      rx_cont      <= 1'b0;
      rx_nine      <= 1'b0;
      hold_full    <= 1'b0;
      tx_frame     <= '0;
      tx_bits_left <= '0;
      tx_level     <= 1'b1;
      rx_phase     <= usart_pkg::RX_OFF;
      rx_frame     <= '0;
      rx_bits_left <= '0;
      line_level   <= 1'b1;
      fifo_count   <= '0;
      overrun      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      port_en      <= port_en_next;
      tx_en        <= tx_en_next;
      tx_nine      <= tx_nine_next;
      tx_ninth     <= tx_ninth_next;
      rx_cont      <= rx_cont_next;
      rx_nine      <= rx_nine_next;
      hold_full    <= hold_full_next;
      tx_frame     <= tx_frame_next;
      tx_bits_left <= tx_bits_left_next;
      tx_level     <= tx_level_next;
      rx_phase     <= rx_phase_next;
      rx_frame     <= rx_frame_next;
      rx_bits_left <= rx_bits_left_next;
      line_level   <= line_level_next;
      fifo_count   <= fifo_count_next;
      overrun      <= overrun_next;
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`include "usart_async_tx_rx_macros.svh"

  `USART_ASSERT(a_fifo_bound, fifo_count <= CNT_W'(FIFO_DEPTH))
  `USART_ASSERT(a_rx_off_when_port_off, !port_en |-> rx_phase == usart_pkg::RX_OFF)
  `USART_ASSERT(a_overrun_on_full, (fire && !cfg_we && q_cmd.act == usart_pkg::ACT_RX_SAMPLE
    && rx_phase == usart_pkg::RX_DATA && rx_bits_left == '0 && q_cmd.sample
    && fifo_count == CNT_W'(FIFO_DEPTH)) |=> overrun)

endmodule

FILE: rtl/usart_async_tx_rx.sv
// Asynchronous serial transmitter and receiver, top level.
//
// Commands arrive one beat at a time on the s_ stream: the action code in
// tuser (tx bit tick, rx line change, rx bit samples, tx write, rx read) and
// its operands in tdata. Each command yields exactly one status beat on the
// m_ stream, in order. A decoder votes the three rx samples and queues the
// command in a two-entry queue; the engine executes one command per clock
// while no configuration write or unaccepted status beat holds it off, so
// the sustained rate is one beat per cycle. A command passes through its
// queue entry and the result register before its status beat is presented;
// while that beat waits, command execution stalls, though the queue can
// still take new commands. Configuration writes take effect at the edge
// they are accepted and hold off command execution for that cycle; the user
// must make them only while no command is in flight, which the block does
// not enforce. The receive FIFO is FIFO_DEPTH bytes deep; a good frame
// arriving with the FIFO full is dropped and sets the sticky overrun flag.
module usart_async_tx_rx #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] rx_level, [3:1] rx_samples, [11:4] tx_byte, [15:12] zero
  input  logic [usart_pkg::IN_DATA_W-1:0]     s_tdata,
  // [2:0] action
  input  logic [usart_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] tx_line, [1] tx_buffer_empty, [2] tx_shifter_empty, [10:3] rx_byte,
  // [11] rx_ready, [12] rx_overrun, [15:13] zero
  output logic [usart_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [usart_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                                cfg_data
);

  logic            q_valid;
  logic            q_pop;
  usart_pkg::cmd_t q_cmd;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  usart_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  usart_engine #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
